/* sv/srtq_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srtq_pkg: shared types and constants for the servo ramp task queue
// Command opcodes and fixed field widths used by the interfaces and the core.
// ----------------------------------------------------------------------------
package srtq_pkg;

	localparam int OPCODE_W = 2;
	localparam int CH_W     = 4;
	localparam int DELAY_W  = 8;
	localparam int GAP_W    = 2;

	// idle ticks after a move ends before the next pop
	localparam logic [GAP_W-1:0] GAP_TICKS = 2'd2;

	typedef enum logic [OPCODE_W-1:0] {
		OP_INIT  = 2'd0,
		OP_PUSH  = 2'd1,
		OP_CLEAR = 2'd2,
		OP_TICK  = 2'd3
	} op_t;

endpackage

/* sv/srtq_cmd_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srtq_cmd_if: command channel
// Valid/ready channel carrying one command transaction per handshake.
// ----------------------------------------------------------------------------
interface srtq_cmd_if #(
	parameter int PULSE_BITS = 12
) ();
	import srtq_pkg::*;

	logic                  valid;
	logic                  ready;
	op_t                   opcode;
	logic [CH_W-1:0]       channel;
	logic [PULSE_BITS-1:0] pulse_value;
	logic [PULSE_BITS-1:0] limit_low;
	logic [PULSE_BITS-1:0] limit_high;
	logic [DELAY_W-1:0]    step_delay;

	modport source (
		output valid, opcode, channel, pulse_value, limit_low, limit_high, step_delay,
		input  ready
	);

	modport sink (
		input  valid, opcode, channel, pulse_value, limit_low, limit_high, step_delay,
		output ready
	);
endinterface

/* sv/srtq_rsp_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srtq_rsp_if: response channel
// Valid/ready channel carrying one result transaction per command.
// ----------------------------------------------------------------------------
interface srtq_rsp_if #(
	parameter int PULSE_BITS = 12
) ();
	import srtq_pkg::*;

	logic                  valid;
	logic                  ready;
	logic                  write_valid;
	logic [CH_W-1:0]       write_channel;
	logic [PULSE_BITS-1:0] write_pulse;
	logic                  queue_empty;
	logic                  push_dropped;

	modport source (
		output valid, write_valid, write_channel, write_pulse, queue_empty, push_dropped,
		input  ready
	);

	modport sink (
		input  valid, write_valid, write_channel, write_pulse, queue_empty, push_dropped,
		output ready
	);
endinterface

/* sv/servo_ramp_task_queue_top.sv */
`timescale 1ns / 1ps
// Each command passes through two registers on its way to its result: the input reg, then the result reg.
// Throughput: 1 command per cycle while rsp.ready keeps the result register draining; the limit is
//   the combinational state update (one channel table read, clamp, step and write) between the two registers.
// Reset (arst_n low, async): queue empty, no move running, gap count zero,
//   min limits zero, max limits all ones, current pulses zero. No clearing pass.
// ----------------------------------------------------------------------------
// servo_ramp_task_queue_top: multi-channel servo pulse ramper with task queue
// Init sets a channel, push queues a ramp task, clear empties the queue and
// tick pops the head task and advances its ramp by one count every step_delay ticks.
// ----------------------------------------------------------------------------
module servo_ramp_task_queue_top #(
	parameter int CHANNELS    = 16,
	parameter int QUEUE_DEPTH = 16,
	parameter int PULSE_BITS  = 12
) (
	input  logic       clk,
	input  logic       arst_n,
	srtq_cmd_if.sink   cmd,
	srtq_rsp_if.source rsp
);
	import srtq_pkg::*;

	localparam int CH_IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam int Q_IDX_W  = $clog2(QUEUE_DEPTH);
	localparam int CNT_W    = $clog2(QUEUE_DEPTH + 1);

	localparam logic [CH_W:0]      CH_LIMIT = (CH_W + 1)'(CHANNELS);
	localparam logic [CNT_W-1:0]   Q_FULL   = CNT_W'(QUEUE_DEPTH);
	localparam logic [CNT_W:0]     Q_WRAP   = (CNT_W + 1)'(QUEUE_DEPTH);
	localparam logic [Q_IDX_W-1:0] Q_LAST   = Q_IDX_W'(QUEUE_DEPTH - 1);

	typedef struct packed {
		logic [CH_W-1:0]       channel;
		logic [PULSE_BITS-1:0] target;
		logic [DELAY_W-1:0]    delay;
	} task_t;

	// ------------------------------------------------------------------
	// Input register (stage 1)
	// ------------------------------------------------------------------
	logic                  valid_s1;
	op_t                   op_s1;
	logic [CH_W-1:0]       ch_s1;
	logic [PULSE_BITS-1:0] pv_s1;
	logic [PULSE_BITS-1:0] lo_s1;
	logic [PULSE_BITS-1:0] hi_s1;
	logic [DELAY_W-1:0]    sd_s1;

	logic rsp_valid_q;
	logic take_s1;
	logic cmd_fire;

	// stage 1 moves on when the result register is free or being drained
	assign take_s1   = valid_s1 && (!rsp_valid_q || rsp.ready);
	assign cmd.ready = !valid_s1 || take_s1;
	assign cmd_fire  = cmd.valid && cmd.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (cmd_fire) begin
			valid_s1 <= 1'b1;
		end else if (take_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_fire) begin
			op_s1 <= cmd.opcode;
			ch_s1 <= cmd.channel;
			pv_s1 <= cmd.pulse_value;
			lo_s1 <= cmd.limit_low;
			hi_s1 <= cmd.limit_high;
			sd_s1 <= cmd.step_delay;
		end
	end

	// ------------------------------------------------------------------
	// Architectural state
	// ------------------------------------------------------------------
	logic [PULSE_BITS-1:0] min_q [CHANNELS];
	logic [PULSE_BITS-1:0] max_q [CHANNELS];
	logic [PULSE_BITS-1:0] cur_q [CHANNELS];

	logic [Q_IDX_W-1:0]    head_q,    head_n;
	logic [CNT_W-1:0]      count_q,   count_n;
	logic                  moving_q,  moving_n;
	logic [CH_W-1:0]       mv_ch_q,   mv_ch_n;
	logic [PULSE_BITS-1:0] mv_tgt_q,  mv_tgt_n;
	logic [DELAY_W-1:0]    mv_dly_q,  mv_dly_n;
	logic [DELAY_W-1:0]    step_cd_q, step_cd_n;
	logic [GAP_W-1:0]      gap_q,     gap_n;

	// task queue memory, with the entry at the head prefetched into a register
	task_t task_mem [QUEUE_DEPTH];
	task_t head_task_q;
	task_t push_task;

	// ------------------------------------------------------------------
	// Next-state logic for the item in stage 1
	// ------------------------------------------------------------------
	logic                  ch_ok;
	logic [CH_IDX_W-1:0]   ch_idx;
	logic [DELAY_W-1:0]    pop_dly;
	logic [CH_W-1:0]       rd_ch;
	logic                  rd_ok;
	logic [CH_IDX_W-1:0]   rd_idx;
	logic [PULSE_BITS-1:0] rd_cur;
	logic [PULSE_BITS-1:0] rd_min;
	logic [PULSE_BITS-1:0] rd_max;
	logic [PULSE_BITS-1:0] pop_tgt;
	logic [PULSE_BITS-1:0] adv_tgt;
	logic [DELAY_W-1:0]    adv_dly;
	logic [PULSE_BITS-1:0] adv_step;
	logic                  adv_done;
	logic                  do_adv;
	logic [CNT_W:0]        tail_sum;
	logic [Q_IDX_W-1:0]    tail_idx;
	logic                  mem_we;
	logic                  tab_we;
	logic                  cur_we;
	logic [CH_IDX_W-1:0]   cur_wi;
	logic [PULSE_BITS-1:0] cur_wd;
	logic                  wv_n;
	logic [CH_W-1:0]       wch_n;
	logic [PULSE_BITS-1:0] wp_n;
	logic                  drop_n;

	assign ch_ok  = {1'b0, ch_s1} < CH_LIMIT;
	assign ch_idx = ch_s1[CH_IDX_W-1:0];

	assign push_task = '{channel: ch_s1, target: pv_s1, delay: sd_s1};

	// a zero step delay acts as one
	assign pop_dly = (head_task_q.delay == '0) ? DELAY_W'(1) : head_task_q.delay;

	// one table read port: the running move's channel, else the head task's
	assign rd_ch  = moving_q ? mv_ch_q : head_task_q.channel;
	assign rd_ok  = {1'b0, rd_ch} < CH_LIMIT;
	assign rd_idx = rd_ch[CH_IDX_W-1:0];
	assign rd_cur = cur_q[rd_idx];
	assign rd_min = min_q[rd_idx];
	assign rd_max = max_q[rd_idx];

	// end value latched at a pop: clamp toward the limit, never past current
	always_comb begin
		pop_tgt = head_task_q.target;
		if (!rd_ok) begin
			pop_tgt = '0;
		end else if (head_task_q.target > rd_cur) begin
			if (rd_max < head_task_q.target) begin
				pop_tgt = rd_max;
			end
			if (rd_max < rd_cur) begin
				pop_tgt = rd_cur;
			end
		end else begin
			if (rd_min > head_task_q.target) begin
				pop_tgt = rd_min;
			end
			if (rd_min > rd_cur) begin
				pop_tgt = rd_cur;
			end
		end
	end

	assign adv_tgt  = moving_q ? mv_tgt_q : pop_tgt;
	assign adv_dly  = moving_q ? mv_dly_q : pop_dly;
	assign adv_step = (rd_cur < adv_tgt) ? rd_cur + 1'b1 : rd_cur - 1'b1;
	assign adv_done = !rd_ok || (rd_cur == adv_tgt);

	// tail = (head + count) mod depth; the sum stays below twice the depth
	assign tail_sum = (CNT_W + 1)'(head_q) + (CNT_W + 1)'(count_q);
	assign tail_idx = (tail_sum >= Q_WRAP) ? Q_IDX_W'(tail_sum - Q_WRAP)
	                                       : Q_IDX_W'(tail_sum);

	always_comb begin
		head_n    = head_q;
		count_n   = count_q;
		moving_n  = moving_q;
		mv_ch_n   = mv_ch_q;
		mv_tgt_n  = mv_tgt_q;
		mv_dly_n  = mv_dly_q;
		step_cd_n = step_cd_q;
		gap_n     = gap_q;
		mem_we    = 1'b0;
		tab_we    = 1'b0;
		cur_we    = 1'b0;
		cur_wi    = ch_idx;
		cur_wd    = pv_s1;
		wv_n      = 1'b0;
		wch_n     = '0;
		wp_n      = '0;
		drop_n    = 1'b0;
		do_adv    = 1'b0;

		if (take_s1) begin
			unique case (op_s1)
				OP_INIT: begin
					if (ch_ok) begin
						tab_we = 1'b1;
						cur_we = 1'b1;
						wv_n   = 1'b1;
						wch_n  = ch_s1;
						wp_n   = pv_s1;
					end
				end
				OP_PUSH: begin
					if (count_q == Q_FULL) begin
						drop_n = 1'b1;
					end else begin
						mem_we  = 1'b1;
						count_n = count_q + 1'b1;
					end
				end
				OP_CLEAR: begin
					count_n = '0;
				end
				OP_TICK: begin
					if (moving_q) begin
						if (step_cd_q > DELAY_W'(1)) begin
							step_cd_n = step_cd_q - 1'b1;
						end else begin
							do_adv = 1'b1;
						end
					end else if (count_q != '0) begin
						if (gap_q != '0) begin
							gap_n = gap_q - 1'b1;
						end else begin
							do_adv   = 1'b1;
							head_n   = (head_q == Q_LAST) ? '0 : head_q + 1'b1;
							count_n  = count_q - 1'b1;
							mv_ch_n  = head_task_q.channel;
							mv_dly_n = pop_dly;
							mv_tgt_n = pop_tgt;
						end
					end
				end
			endcase

			if (do_adv) begin
				if (adv_done) begin
					moving_n = 1'b0;
					gap_n    = GAP_TICKS;
				end else begin
					moving_n  = 1'b1;
					cur_we    = 1'b1;
					cur_wi    = rd_idx;
					cur_wd    = adv_step;
					wv_n      = 1'b1;
					wch_n     = rd_ch;
					wp_n      = adv_step;
					step_cd_n = adv_dly;
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// State registers
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q    <= '0;
			count_q   <= '0;
			moving_q  <= 1'b0;
			mv_ch_q   <= '0;
			mv_tgt_q  <= '0;
			mv_dly_q  <= '0;
			step_cd_q <= '0;
			gap_q     <= '0;
		end else begin
			head_q    <= head_n;
			count_q   <= count_n;
			moving_q  <= moving_n;
			mv_ch_q   <= mv_ch_n;
			mv_tgt_q  <= mv_tgt_n;
			mv_dly_q  <= mv_dly_n;
			step_cd_q <= step_cd_n;
			gap_q     <= gap_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < CHANNELS; i++) begin
				min_q[i] <= '0;
				max_q[i] <= '1;
				cur_q[i] <= '0;
			end
		end else begin
			if (tab_we) begin
				min_q[ch_idx] <= lo_s1;
				max_q[ch_idx] <= hi_s1;
			end
			if (cur_we) begin
				cur_q[cur_wi] <= cur_wd;
			end
		end
	end

	// queue memory; the read at the next head is registered, with the
	// push data forwarded when it lands on that same entry
	always_ff @(posedge clk) begin
		if (mem_we) begin
			task_mem[tail_idx] <= push_task;
		end
		if (mem_we && (tail_idx == head_n)) begin
			head_task_q <= push_task;
		end else begin
			head_task_q <= task_mem[head_n];
		end
	end

	// ------------------------------------------------------------------
	// Result register
	// ------------------------------------------------------------------
	logic                  wv_q;
	logic [CH_W-1:0]       wch_q;
	logic [PULSE_BITS-1:0] wp_q;
	logic                  empty_q;
	logic                  drop_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (take_s1) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take_s1) begin
			wv_q    <= wv_n;
			wch_q   <= wch_n;
			wp_q    <= wp_n;
			empty_q <= (count_n == '0);
			drop_q  <= drop_n;
		end
	end

	assign rsp.valid         = rsp_valid_q;
	assign rsp.write_valid   = wv_q;
	assign rsp.write_channel = wch_q;
	assign rsp.write_pulse   = wp_q;
	assign rsp.queue_empty   = empty_q;
	assign rsp.push_dropped  = drop_q;

	// ------------------------------------------------------------------
	// Assertions
	// ------------------------------------------------------------------
`ifndef SYNTH
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= Q_FULL)
		else $error("task queue count exceeds depth");

	a_gap_bound: assert property (@(posedge clk) disable iff (!arst_n)
		gap_q <= GAP_TICKS)
		else $error("gap countdown out of range");

	a_move_delay: assert property (@(posedge clk) disable iff (!arst_n)
		moving_q |-> (mv_dly_q != '0) && (step_cd_q != '0))
		else $error("running move with zero step delay");

	a_no_write_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && !rsp.write_valid) |-> (rsp.write_channel == '0) && (rsp.write_pulse == '0))
		else $error("write fields nonzero without a write");

	a_drop_not_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && rsp.push_dropped) |-> !rsp.queue_empty)
		else $error("dropped push reported with empty queue");
`endif

endmodule
